@@ rtl/qmca_pkg.sv @@
// ============================================================================
// qmca_pkg
// Shared constants, status codes and stage payload types for the quad
// minimum corner area ratio pipeline.
// ============================================================================
package qmca_pkg;

    // Field and datapath widths.
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 15;
    localparam int FLOOR_W    = 20;
    localparam int RATIO_W    = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int AREA_W     = PROD_W + 1;
    localparam int Q_W        = FRAC_BITS + 1;

    // A ratio of exactly one in the quotient format.
    localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_QUAD = 2'd1,
        ST_DEGEN    = 2'd2,
        ST_NEG      = 2'd3
    } status_t;

    // One input cell.
    typedef struct packed {
        logic                         is_quad;
        logic signed [COORD_BITS-1:0] x_0;
        logic signed [COORD_BITS-1:0] y_0;
        logic signed [COORD_BITS-1:0] x_1;
        logic signed [COORD_BITS-1:0] y_1;
        logic signed [COORD_BITS-1:0] x_2;
        logic signed [COORD_BITS-1:0] y_2;
        logic signed [COORD_BITS-1:0] x_3;
        logic signed [COORD_BITS-1:0] y_3;
    } in_t;

    // One result.
    typedef struct packed {
        logic [RATIO_W-1:0] min_ratio;
        logic [1:0]         status;
    } out_t;

    // Coordinate differences.
    typedef struct packed {
        logic                         is_quad;
        logic signed [COORD_BITS-1:0] y0;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] y2;
        logic signed [COORD_BITS-1:0] y3;
        logic signed [DIFF_W-1:0]     d20;
        logic signed [DIFF_W-1:0]     d31;
        logic signed [DIFF_W-1:0]     dy20;
        logic signed [DIFF_W-1:0]     dy31;
        logic signed [DIFF_W-1:0]     d03;
        logic signed [DIFF_W-1:0]     d10;
        logic signed [DIFF_W-1:0]     d21;
        logic signed [DIFF_W-1:0]     d32;
    } diff_t;

    // Partial products of the area and the four corner numerators.
    typedef struct packed {
        logic                     is_quad;
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
        logic signed [PROD_W-1:0] n0a;
        logic signed [PROD_W-1:0] n0b;
        logic signed [PROD_W-1:0] n0c;
        logic signed [PROD_W-1:0] n1a;
        logic signed [PROD_W-1:0] n1b;
        logic signed [PROD_W-1:0] n1c;
        logic signed [PROD_W-1:0] n2a;
        logic signed [PROD_W-1:0] n2b;
        logic signed [PROD_W-1:0] n2c;
        logic signed [PROD_W-1:0] n3a;
        logic signed [PROD_W-1:0] n3b;
        logic signed [PROD_W-1:0] n3c;
    } prod_t;

    // Doubled area and corner numerators.
    typedef struct packed {
        logic                     is_quad;
        logic signed [AREA_W-1:0] a2;
        logic signed [AREA_W-1:0] num0;
        logic signed [AREA_W-1:0] num1;
        logic signed [AREA_W-1:0] num2;
        logic signed [AREA_W-1:0] num3;
    } sum_t;

    // Area magnitude and orientation-corrected numerators.
    typedef struct packed {
        logic                     is_quad;
        logic                     degen;
        logic        [AREA_W-1:0] amag;
        logic signed [AREA_W-1:0] num0;
        logic signed [AREA_W-1:0] num1;
        logic signed [AREA_W-1:0] num2;
        logic signed [AREA_W-1:0] num3;
    } mag_t;

    // Divider stage payload.
    typedef struct packed {
        status_t           status;
        logic              zero;
        logic              sat;
        logic [AREA_W-1:0] amag;
        logic [AREA_W-1:0] rem;
        logic [Q_W-1:0]    q;
    } div_t;

endpackage

@@ rtl/qmca_front.sv @@
// ============================================================================
// qmca_front
// Three register stages: coordinate differences, products, and the sums
// that form the doubled area and the four corner numerators.
// ============================================================================
module qmca_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  qmca_pkg::in_t   in_data,
    output logic            sum_valid,
    output qmca_pkg::sum_t  sum_data
);

    qmca_pkg::diff_t diff_next;
    qmca_pkg::diff_t diff_reg;
    qmca_pkg::prod_t prod_next;
    qmca_pkg::prod_t prod_reg;
    qmca_pkg::sum_t  sum_next;
    qmca_pkg::sum_t  sum_reg;
    logic            diff_vld_reg;
    logic            prod_vld_reg;
    logic            sum_vld_reg;

    // Differences of the vertex coordinates.
    always_comb
    begin
        diff_next.is_quad = in_data.is_quad;
        diff_next.y0      = in_data.y_0;
        diff_next.y1      = in_data.y_1;
        diff_next.y2      = in_data.y_2;
        diff_next.y3      = in_data.y_3;
        diff_next.d20     = qmca_pkg::DIFF_W'(in_data.x_2) - qmca_pkg::DIFF_W'(in_data.x_0);
        diff_next.d31     = qmca_pkg::DIFF_W'(in_data.x_3) - qmca_pkg::DIFF_W'(in_data.x_1);
        diff_next.dy20    = qmca_pkg::DIFF_W'(in_data.y_2) - qmca_pkg::DIFF_W'(in_data.y_0);
        diff_next.dy31    = qmca_pkg::DIFF_W'(in_data.y_3) - qmca_pkg::DIFF_W'(in_data.y_1);
        diff_next.d03     = qmca_pkg::DIFF_W'(in_data.x_0) - qmca_pkg::DIFF_W'(in_data.x_3);
        diff_next.d10     = qmca_pkg::DIFF_W'(in_data.x_1) - qmca_pkg::DIFF_W'(in_data.x_0);
        diff_next.d21     = qmca_pkg::DIFF_W'(in_data.x_2) - qmca_pkg::DIFF_W'(in_data.x_1);
        diff_next.d32     = qmca_pkg::DIFF_W'(in_data.x_3) - qmca_pkg::DIFF_W'(in_data.x_2);
    end

    // All products in parallel, each one multiplier wide.
    always_comb
    begin
        prod_next.is_quad = diff_reg.is_quad;
        prod_next.pa      = diff_reg.d20 * diff_reg.dy31;
        prod_next.pb      = diff_reg.d31 * diff_reg.dy20;
        prod_next.n0a     = diff_reg.y0 * diff_reg.d31;
        prod_next.n0b     = diff_reg.y1 * diff_reg.d03;
        prod_next.n0c     = diff_reg.y3 * diff_reg.d10;
        prod_next.n1a     = diff_reg.y1 * diff_reg.d20;
        prod_next.n1b     = diff_reg.y2 * diff_reg.d10;
        prod_next.n1c     = diff_reg.y0 * diff_reg.d21;
        prod_next.n2a     = diff_reg.y2 * diff_reg.d31;
        prod_next.n2b     = diff_reg.y3 * diff_reg.d21;
        prod_next.n2c     = diff_reg.y1 * diff_reg.d32;
        prod_next.n3a     = diff_reg.y3 * diff_reg.d20;
        prod_next.n3b     = diff_reg.y0 * diff_reg.d32;
        prod_next.n3c     = diff_reg.y2 * diff_reg.d03;
    end

    // Doubled area and corner numerators.
    always_comb
    begin
        sum_next.is_quad = prod_reg.is_quad;
        sum_next.a2      = qmca_pkg::AREA_W'(prod_reg.pa) - qmca_pkg::AREA_W'(prod_reg.pb);
        sum_next.num0    = qmca_pkg::AREA_W'(prod_reg.n0a) + qmca_pkg::AREA_W'(prod_reg.n0b)
                         + qmca_pkg::AREA_W'(prod_reg.n0c);
        sum_next.num1    = qmca_pkg::AREA_W'(prod_reg.n1b) + qmca_pkg::AREA_W'(prod_reg.n1c)
                         - qmca_pkg::AREA_W'(prod_reg.n1a);
        sum_next.num2    = qmca_pkg::AREA_W'(prod_reg.n2b) + qmca_pkg::AREA_W'(prod_reg.n2c)
                         - qmca_pkg::AREA_W'(prod_reg.n2a);
        sum_next.num3    = qmca_pkg::AREA_W'(prod_reg.n3a) + qmca_pkg::AREA_W'(prod_reg.n3b)
                         + qmca_pkg::AREA_W'(prod_reg.n3c);
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            diff_vld_reg <= in_valid;
            prod_vld_reg <= diff_vld_reg;
            sum_vld_reg  <= prod_vld_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum_valid = sum_vld_reg;
    assign sum_data  = sum_reg;

endmodule

@@ rtl/qmca_select.sv @@
// ============================================================================
// qmca_select
// Two register stages: area magnitude with orientation fix, then the
// minimum numerator, the status decision and the divider setup.
// ============================================================================
module qmca_select
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [qmca_pkg::FLOOR_W-1:0]  area_floor,
    input  logic                          sum_valid,
    input  qmca_pkg::sum_t                sum_data,
    output logic                          div_valid,
    output qmca_pkg::div_t                div_data
);

    qmca_pkg::mag_t                   mag_next;
    qmca_pkg::mag_t                   mag_reg;
    qmca_pkg::div_t                   div_next;
    qmca_pkg::div_t                   div_reg;
    logic                             mag_vld_reg;
    logic                             div_vld_reg;
    logic signed [qmca_pkg::AREA_W-1:0] min01;
    logic signed [qmca_pkg::AREA_W-1:0] min23;
    logic signed [qmca_pkg::AREA_W-1:0] nmin;
    logic        [qmca_pkg::AREA_W:0]   twice;

    // Magnitude of the doubled area; numerators flip with a negative area.
    always_comb
    begin
        mag_next.is_quad = sum_data.is_quad;
        mag_next.amag    = sum_data.a2[qmca_pkg::AREA_W-1] ? -sum_data.a2 : sum_data.a2;
        mag_next.degen   = (mag_next.amag <= qmca_pkg::AREA_W'(area_floor));
        if (sum_data.a2[qmca_pkg::AREA_W-1])
        begin
            mag_next.num0 = -sum_data.num0;
            mag_next.num1 = -sum_data.num1;
            mag_next.num2 = -sum_data.num2;
            mag_next.num3 = -sum_data.num3;
        end
        else
        begin
            mag_next.num0 = sum_data.num0;
            mag_next.num1 = sum_data.num1;
            mag_next.num2 = sum_data.num2;
            mag_next.num3 = sum_data.num3;
        end
    end

    // Minimum numerator through a two-level compare tree.
    always_comb
    begin
        min01 = (mag_reg.num1 < mag_reg.num0) ? mag_reg.num1 : mag_reg.num0;
        min23 = (mag_reg.num3 < mag_reg.num2) ? mag_reg.num3 : mag_reg.num2;
        nmin  = (min23 < min01) ? min23 : min01;
        twice = {nmin, 1'b0};
    end

    // Status decision and divider setup.
    always_comb
    begin
        div_next.amag = mag_reg.amag;
        div_next.rem  = qmca_pkg::AREA_W'(twice);
        div_next.q    = '0;
        div_next.sat  = (twice >= {1'b0, mag_reg.amag});
        div_next.zero = 1'b1;
        priority if (!mag_reg.is_quad)
        begin
            div_next.status = qmca_pkg::ST_NOT_QUAD;
        end
        else if (mag_reg.degen)
        begin
            div_next.status = qmca_pkg::ST_DEGEN;
        end
        else if (nmin[qmca_pkg::AREA_W-1])
        begin
            div_next.status = qmca_pkg::ST_NEG;
        end
        else
        begin
            div_next.status = qmca_pkg::ST_OK;
            div_next.zero   = (nmin == '0);
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg <= 1'b0;
            div_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            mag_vld_reg <= sum_valid;
            div_vld_reg <= mag_vld_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            div_reg <= div_next;
        end
    end

    assign div_valid = div_vld_reg;
    assign div_data  = div_reg;

endmodule

@@ rtl/qmca_div.sv @@
// ============================================================================
// qmca_div
// Restoring divider, one quotient bit per register stage, followed by
// the saturation and zero selection of the final ratio.
// ============================================================================
module qmca_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            div_valid,
    input  qmca_pkg::div_t  div_data,
    output logic            out_valid,
    output qmca_pkg::out_t  out_data
);

    qmca_pkg::div_t stage_reg [qmca_pkg::FRAC_BITS];
    logic           vld_reg   [qmca_pkg::FRAC_BITS];
    qmca_pkg::div_t last;

    for (genvar k = 0; k < qmca_pkg::FRAC_BITS; k++)
    begin : g_step
        qmca_pkg::div_t              prev;
        logic                        prev_vld;
        logic [qmca_pkg::AREA_W:0]   shifted;
        logic                        ge;
        qmca_pkg::div_t              step_next;

        // The first stage takes the setup payload, the others the stage before.
        assign prev     = (k == 0) ? div_data  : stage_reg[(k == 0) ? 0 : k - 1];
        assign prev_vld = (k == 0) ? div_valid : vld_reg[(k == 0) ? 0 : k - 1];

        // One shift, compare and subtract per stage.
        always_comb
        begin
            shifted        = {prev.rem, 1'b0};
            ge             = (shifted >= {1'b0, prev.amag});
            step_next      = prev;
            step_next.rem  = ge ? qmca_pkg::AREA_W'(shifted - {1'b0, prev.amag})
                                : qmca_pkg::AREA_W'(shifted);
            step_next.q    = {prev.q[qmca_pkg::Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= step_next;
            end
        end
    end

    // Final selection of the ratio from the last stage.
    assign last = stage_reg[qmca_pkg::FRAC_BITS-1];

    always_comb
    begin
        out_data.status = last.status;
        if (last.zero)
        begin
            out_data.min_ratio = '0;
        end
        else if (last.sat)
        begin
            out_data.min_ratio = qmca_pkg::RATIO_W'(qmca_pkg::Q_ONE);
        end
        else
        begin
            out_data.min_ratio = qmca_pkg::RATIO_W'(last.q);
        end
    end

    assign out_valid = vld_reg[qmca_pkg::FRAC_BITS-1];

endmodule

@@ rtl/quad_min_corner_area_ratio_core.sv @@
// Pipeline: 5 arithmetic stages and 15 divider stages from input transfer to result.
// Throughput: one cell per cycle unless a result stalls; one quotient bit per stage.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits and sets area_floor to 0; no clearing pass.
// ============================================================================
// quad_min_corner_area_ratio_core
// Minimum relative corner area of a quadrilateral cell as an unsigned
// Q1.15 fraction with a status code, one cell per cycle unless the output stalls.
// ============================================================================
module quad_min_corner_area_ratio_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qmca_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qmca_pkg::out_t                out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qmca_pkg::FLOOR_W-1:0]  cfg_data
);

    logic                          en;
    logic [qmca_pkg::FLOOR_W-1:0]  area_floor_reg;
    logic                          sum_valid;
    qmca_pkg::sum_t                sum_data;
    logic                          div_valid;
    qmca_pkg::div_t                div_data;

    // The pipeline advances unless a finished result is held by the sink.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Configuration register, written on every configuration transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_floor_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            area_floor_reg <= cfg_data;
        end
    end

    // Differences, products and sums.
    qmca_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .sum_valid (sum_valid),
        .sum_data  (sum_data)
    );

    // Magnitude, minimum and status.
    qmca_select u_select
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .area_floor (area_floor_reg),
        .sum_valid  (sum_valid),
        .sum_data   (sum_data),
        .div_valid  (div_valid),
        .div_data   (div_data)
    );

    // Quotient bits and final ratio.
    qmca_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_valid (div_valid),
        .div_data  (div_data),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for quad_min_corner_area_ratio_core. Cells are
// sent over the valid/stall input channel. An integer model in this file
// predicts the ratio and status of each cell. Every result transfer is
// compared with the oldest prediction still waiting. The run covers the
// special cases, several area floor settings, random idling on both
// channels, a long output hold and a full drain between bursts.
// ============================================================================
module tb_top;

    localparam int LATENCY    = 20;
    localparam int END_WAIT   = 2 * LATENCY + 10;
    localparam int MAX_CYCLES = 1000000;
    localparam logic [qmca_pkg::FLOOR_W-1:0] FLOOR_MAX = '1;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    qmca_pkg::in_t                in_data;
    logic                         out_valid;
    logic                         out_stall;
    qmca_pkg::out_t               out_data;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [qmca_pkg::FLOOR_W-1:0] cfg_data;

    // Predicted results in transfer order, and the floor the block holds.
    qmca_pkg::out_t               pending_results[$];
    logic [qmca_pkg::FLOOR_W-1:0] floor_model;

    int error_count    = 0;
    int cycle_count    = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;

    quad_min_corner_area_ratio_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit, counted in clock cycles.
    initial
    begin
        while (cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Saturate an integer into the coordinate range.
    function automatic logic signed [qmca_pkg::COORD_BITS-1:0] to_coord(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return qmca_pkg::COORD_BITS'(v);
    endfunction

    function automatic qmca_pkg::in_t make_quad(bit quad_flag, int x0, int y0, int x1, int y1,
                                                int x2, int y2, int x3, int y3);
        qmca_pkg::in_t q;
        q.is_quad = quad_flag;
        q.x_0 = to_coord(x0);
        q.y_0 = to_coord(y0);
        q.x_1 = to_coord(x1);
        q.y_1 = to_coord(y1);
        q.x_2 = to_coord(x2);
        q.y_2 = to_coord(y2);
        q.x_3 = to_coord(x3);
        q.y_3 = to_coord(y3);
        return q;
    endfunction

    // Minimum relative corner area of one cell under the given floor.
    function automatic qmca_pkg::out_t predict_min_corner_ratio(
        qmca_pkg::in_t q, logic [qmca_pkg::FLOOR_W-1:0] floor_val);
        longint px[4];
        longint py[4];
        longint corner[4];
        longint d20, d31, d03, d10, d21, d32, a2, nmin;
        longint unsigned amag, twice;
        qmca_pkg::out_t r;
        r.min_ratio = '0;
        r.status    = qmca_pkg::ST_OK;
        if (!q.is_quad)
        begin
            r.status = qmca_pkg::ST_NOT_QUAD;
            return r;
        end
        px[0] = q.x_0;
        py[0] = q.y_0;
        px[1] = q.x_1;
        py[1] = q.y_1;
        px[2] = q.x_2;
        py[2] = q.y_2;
        px[3] = q.x_3;
        py[3] = q.y_3;

        // Doubled area from the cross product of the diagonals.
        d20  = px[2] - px[0];
        d31  = px[3] - px[1];
        a2   = d20 * (py[3] - py[1]) - d31 * (py[2] - py[0]);
        amag = (a2 < 0) ? -a2 : a2;
        if (amag <= floor_val)
        begin
            r.status = qmca_pkg::ST_DEGEN;
            return r;
        end

        // Corner numerators, oriented so that the area is positive.
        d03 = px[0] - px[3];
        d10 = px[1] - px[0];
        d21 = px[2] - px[1];
        d32 = px[3] - px[2];
        corner[0] = py[0] * d31 + py[1] * d03 + py[3] * d10;
        corner[1] = -(py[1] * d20) + py[2] * d10 + py[0] * d21;
        corner[2] = -(py[2] * d31) + py[3] * d21 + py[1] * d32;
        corner[3] = py[3] * d20 + py[0] * d32 + py[2] * d03;
        nmin = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (a2 < 0)
                corner[i] = -corner[i];
            if (i == 0 || corner[i] < nmin)
                nmin = corner[i];
        end

        if (nmin < 0)
        begin
            r.status = qmca_pkg::ST_NEG;
            return r;
        end
        if (nmin == 0)
            return r;

        // Ratio 2*N/A in fixed point, truncated, saturating at one.
        twice = 2 * nmin;
        if (twice >= amag)
            r.min_ratio = qmca_pkg::RATIO_W'(longint'(1) << qmca_pkg::FRAC_BITS);
        else
            r.min_ratio = qmca_pkg::RATIO_W'((twice << qmca_pkg::FRAC_BITS) / amag);
        return r;
    endfunction

    // Random cell: mostly well-formed quads of many sizes, plus noise.
    function automatic qmca_pkg::in_t random_quad();
        int  xs[4];
        int  ys[4];
        int  p[4];
        int  kind, cx, cy, r, start, k;
        bit  reverse, quad_flag;
        kind      = $urandom_range(99);
        quad_flag = ($urandom_range(99) >= 3);
        cx = int'($urandom_range(65535)) - 32768;
        cy = int'($urandom_range(65535)) - 32768;
        r  = $urandom_range(1, 1 << $urandom_range(0, 15));
        xs[0] = cx - int'($urandom_range(r));
        ys[0] = cy - int'($urandom_range(r));
        xs[1] = cx + int'($urandom_range(r));
        ys[1] = cy - int'($urandom_range(r));
        xs[2] = cx + int'($urandom_range(r));
        ys[2] = cy + int'($urandom_range(r));
        xs[3] = cx - int'($urandom_range(r));
        ys[3] = cy + int'($urandom_range(r));
        if (kind < 10)
        begin
            // Raw bits in every field.
            quad_flag = $urandom_range(1);
            for (int i = 0; i < 4; i++)
            begin
                xs[i] = int'($urandom_range(65535)) - 32768;
                ys[i] = int'($urandom_range(65535)) - 32768;
            end
        end
        else if (kind < 20)
        begin
            // Coordinates pushed to the ends of the range.
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(3))
                    0: xs[i] = -32768;
                    1: xs[i] = 32767;
                    default: ;
                endcase
                case ($urandom_range(3))
                    0: ys[i] = -32768;
                    1: ys[i] = 32767;
                    default: ;
                endcase
            end
        end
        else if (kind < 30)
        begin
            // Dart: one vertex pulled past the center, so one corner is reflex.
            xs[2] = cx - int'($urandom_range(r)) / 2;
            ys[2] = cy - int'($urandom_range(r)) / 2;
        end
        else if (kind < 36)
        begin
            // Two coincident vertices.
            k = $urandom_range(3);
            xs[(k + 1) % 4] = xs[k];
            ys[(k + 1) % 4] = ys[k];
        end

        // Random starting vertex and winding.
        start   = $urandom_range(3);
        reverse = $urandom_range(1);
        for (int i = 0; i < 4; i++)
            p[i] = reverse ? (start + 4 - i) % 4 : (start + i) % 4;
        return make_quad(quad_flag, xs[p[0]], ys[p[0]], xs[p[1]], ys[p[1]],
                         xs[p[2]], ys[p[2]], xs[p[3]], ys[p[3]]);
    endfunction

    // Offer one cell and hold it until the transfer happens.
    task automatic send_quad(input qmca_pkg::in_t item);
        int gap;
        gap = 0;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
            gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        pending_results.push_back(predict_min_corner_ratio(item, floor_model));
        @(posedge clk);
    endtask

    // Stop offering and wait for every predicted result to come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the area floor; the block must be idle.
    task automatic write_area_floor(input logic [qmca_pkg::FLOOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        floor_model = value;
        cfg_valid  <= 1'b0;
    endtask

    // Hand-built cells for each special case, with the floor at reset value.
    task automatic test_special_cases();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_quad(make_quad(0, 10, 20, 30, 40, 50, 60, 70, 80));
        send_quad(make_quad(0, 32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        send_quad(make_quad(1, 0, 0, 100, 0, 100, 100, 0, 100));
        send_quad(make_quad(1, 0, 0, 0, 100, 100, 100, 100, 0));
        send_quad(make_quad(1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_quad(make_quad(1, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
        send_quad(make_quad(1, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767));
        send_quad(make_quad(1, 0, 0, 100, 50, 0, 100, 30, 50));
        send_quad(make_quad(1, 0, 0, 100, 100, 100, 0, 0, 100));
        send_quad(make_quad(1, 0, 0, 100, 0, 100, 0, 0, 100));
        send_quad(make_quad(1, 0, 0, 300, 0, 200, 100, 100, 100));
        send_quad(make_quad(1, 0, -50, 40, 0, 0, 200, -40, 0));
        send_quad(make_quad(1, -32768, -32768, 32767, -32768, 32767, 32767, -32767, -32766));
        send_quad(make_quad(1, 0, 0, 10, 10, 20, 20, 30, 30));
        send_quad(make_quad(1, -1, -1, -1, 32767, 32767, 32767, 32767, -1));
        send_quad(make_quad(1, -32768, 0, 0, -32768, 32767, 0, 0, 32767));
    endtask

    // Cells whose doubled area sits at, just below and just above the floor.
    task automatic test_floor_limits();
        drain_results();
        write_area_floor(20'd20000);
        send_quad(make_quad(1, 0, 0, 100, 0, 100, 100, 0, 100));
        send_quad(make_quad(1, 0, 0, 101, 0, 101, 101, 0, 101));
        send_quad(make_quad(1, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_results();
        write_area_floor(FLOOR_MAX);
        send_quad(make_quad(1, 0, 0, 724, 0, 724, 724, 0, 724));
        send_quad(make_quad(1, 0, 0, 725, 0, 725, 725, 0, 725));
        send_quad(make_quad(1, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
        send_quad(make_quad(0, 0, 0, 725, 0, 725, 725, 0, 725));
    endtask

    // Random cells under one floor setting and one idling mix.
    task automatic test_random_cells(input int count,
                                     input logic [qmca_pkg::FLOOR_W-1:0] floor_val,
                                     input int gap_pct, input int stall_pct);
        drain_results();
        write_area_floor(floor_val);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_quad(random_quad());
    endtask

    // The receiver holds off for a long stretch while cells keep coming.
    task automatic test_output_hold();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_len       = 300;
        repeat (80) send_quad(random_quad());
    endtask

    // A burst, a full drain with the sender paused, then another burst.
    task automatic test_drain_pause();
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        repeat (80) send_quad(random_quad());
        drain_results();
        repeat (80) send_quad(random_quad());
    endtask

    // Receiver: random stall bursts, or a long hold when one is asked for.
    initial
    begin : output_receiver
        int len;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                len      = hold_len;
                hold_len = 0;
            end
            else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
                len = pick_gap();
            else
                len = 0;
            if (len != 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest prediction.
    initial
    begin : result_checker
        qmca_pkg::out_t expected;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none expected: min_ratio %0d status %0d",
                             $time, out_data.min_ratio, out_data.status);
                end
                else
                begin
                    expected = pending_results.pop_front();
                    if (out_data.min_ratio !== expected.min_ratio)
                    begin
                        error_count++;
                        $display("%0t: min_ratio expected %0d actual %0d",
                                 $time, expected.min_ratio, out_data.min_ratio);
                    end
                    if (out_data.status !== expected.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, expected.status, out_data.status);
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        floor_model = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_floor_limits();
        test_random_cells(320, '0, 25, 25);
        test_random_cells(320, qmca_pkg::FLOOR_W'($urandom_range(1, 1048574)), 30, 30);
        test_random_cells(260, FLOOR_MAX, 0, 0);
        test_random_cells(260, qmca_pkg::FLOOR_W'($urandom_range(1, 5000)), 40, 15);
        test_output_hold();
        test_drain_pause();

        // Let any stray result show up before the verdict.
        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/qmca_pkg.sv
rtl/qmca_front.sv
rtl/qmca_select.sv
rtl/qmca_div.sv
rtl/quad_min_corner_area_ratio_core.sv
test/tb_top.sv
